// File: rtl/core/mf_pkg.sv
`default_nettype none

package mf_pkg;

    // neighborhood size and the count width that holds it
    localparam int NEIGHBORS = 27;
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 5;

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    // configuration data width (widest register)
    localparam int CFG_W = 16;

    // control from the sequencer to the sorter
    typedef struct packed {
        logic clear;
        logic insert;
    } sort_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/mf_ram.sv
`default_nettype none

module mf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/mf_sorter.sv
`default_nettype none

module mf_sorter #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mf_pkg::sort_ctl_t             ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] din,
    output logic signed [SAMPLE_BITS:0]        median_twice
);

    logic signed [SAMPLE_BITS-1:0] sv_reg   [mf_pkg::NEIGHBORS];
    logic signed [SAMPLE_BITS-1:0] sv_next  [mf_pkg::NEIGHBORS];
    logic [mf_pkg::CNT_W-1:0]      cnt_reg;
    logic [mf_pkg::NEIGHBORS-1:0]  gt;
    logic [mf_pkg::CNT_W-1:0]      cnt_dec;
    logic [mf_pkg::IDX_W-1:0]      idx_lo;
    logic [mf_pkg::IDX_W-1:0]      idx_hi;

    // flag every held value above the incoming one
    always_comb
    begin
        for (int i = 0; i < mf_pkg::NEIGHBORS; i++)
        begin
            gt[i] = (mf_pkg::CNT_W'(i) < cnt_reg) && (sv_reg[i] > din);
        end
    end

    // shift the larger values up and drop the new one into the gap
    always_comb
    begin
        for (int i = 0; i < mf_pkg::NEIGHBORS; i++)
        begin
            if ((mf_pkg::CNT_W'(i) < cnt_reg) && !gt[i])
            begin
                sv_next[i] = sv_reg[i];
            end
            else if (i == 0)
            begin
                sv_next[i] = din;
            end
            else if (!gt[i-1])
            begin
                sv_next[i] = din;
            end
            else
            begin
                sv_next[i] = sv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.insert)
        begin
            sv_reg <= sv_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.clear)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.insert)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // the two middle values; they coincide for an odd count
    assign cnt_dec      = cnt_reg - 1'b1;
    assign idx_lo       = cnt_dec >> 1;
    assign idx_hi       = cnt_reg >> 1;
    assign median_twice = (SAMPLE_BITS+1)'(sv_reg[idx_lo]) + (SAMPLE_BITS+1)'(sv_reg[idx_hi]);

endmodule

`default_nettype wire

// File: rtl/core/median_filter_3x3x3_core.sv
`default_nettype none

// 3x3x3 median filter over a stream of volumes in raster order (x fastest).
// Input channel (in_valid/in_ready): command selects a voxel sample or a
// drain item. Output channel (out_valid/out_ready): twice the median of the
// voxel's clipped neighborhood, with last_of_volume on the final voxel.
// A result for a voxel appears once size_x*size_y+size_x+1 later samples are
// in (or the volume is complete); drain items flush the tail of a volume.
// Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle; the
// block does not enforce this. A size write restarts the volume; the new size feeds
// plane_reg, then vol_reg and lag_reg. An item with no result passes S_IDLE and
// S_CHECK; one with a result also steps through S_GATHER, S_FLUSH and S_FINISH:
// the single-port window memory is read once for each of the 27 neighbor slots,
// one per cycle, and each in-volume value goes into a 27-entry sorting register.
// A finished result sits in an output register; the next item is accepted
// while it waits, and the sequencer only holds in its final step when a new
// result is due while the old one is still not taken.
// Reset clears the positions and output valid and loads the default sizes
// (256 x 256 x 1); the window memory needs no clearing.
module median_filter_3x3x3_core #(
    parameter int MAX_SIZE_X  = 256,
    parameter int MAX_SIZE_Y  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           command,
    input  wire logic signed [SAMPLE_BITS-1:0]  sample,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [SAMPLE_BITS:0]         median_twice,
    output logic                                last_of_volume,
    input  wire logic                           cfg_we,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [mf_pkg::CFG_W-1:0]       cfg_data
);

    localparam int XW  = $clog2(MAX_SIZE_X + 1);
    localparam int YW  = $clog2(MAX_SIZE_Y + 1);
    localparam int ZW  = 16;
    localparam int PW  = XW + YW;
    localparam int VW  = PW + ZW;
    localparam int WIN = 2 * MAX_SIZE_X * MAX_SIZE_Y + 2 * MAX_SIZE_X + 3;
    localparam int AW  = $clog2(WIN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_GATHER,
        S_FLUSH,
        S_FINISH
    } state_t;

    state_t                   state_reg;
    logic [8:0]               size_x_reg;
    logic [8:0]               size_y_reg;
    logic [ZW-1:0]            size_z_reg;
    logic [PW-1:0]            plane_reg;
    logic [VW-1:0]            vol_reg;
    logic [PW:0]              lag_reg;
    logic [VW-1:0]            in_pos_reg;
    logic [VW-1:0]            out_pos_reg;
    logic [AW-1:0]            wr_ptr_reg;
    logic [AW-1:0]            ctr_ptr_reg;
    logic [XW-1:0]            ox_reg;
    logic [YW-1:0]            oy_reg;
    logic [ZW-1:0]            oz_reg;
    logic [1:0]               dx_reg;
    logic [1:0]               dy_reg;
    logic [1:0]               dz_reg;
    logic                     rd_valid_reg;
    logic                     out_valid_reg;
    logic signed [SAMPLE_BITS:0] median_reg;
    logic                     last_reg;

    logic [XW-1:0]            sx;
    logic [YW-1:0]            sy;
    logic [ZW-1:0]            sz;
    logic                     in_acc;
    logic                     do_write;
    logic [VW:0]              need;
    logic [VW:0]              need_c;
    logic                     due;
    logic signed [AW+1:0]     nb_sum;
    logic signed [AW+1:0]     z_off;
    logic signed [AW+1:0]     y_off;
    logic signed [AW+1:0]     x_off;
    logic [AW-1:0]            nb_addr;
    logic                     nb_valid;
    logic                     ram_we;
    logic [AW-1:0]            ram_addr;
    logic [SAMPLE_BITS-1:0]   ram_rdata;
    mf_pkg::sort_ctl_t        sort_ctl;
    logic signed [SAMPLE_BITS:0] sort_med;
    logic                     out_free;
    logic                     is_last;

    // clamp the sizes to their legal ranges
    always_comb
    begin
        priority if (size_x_reg == 9'd0)
            sx = XW'(1);
        else if (32'(size_x_reg) > 32'(MAX_SIZE_X))
            sx = XW'(MAX_SIZE_X);
        else
            sx = XW'(size_x_reg);
        priority if (size_y_reg == 9'd0)
            sy = YW'(1);
        else if (32'(size_y_reg) > 32'(MAX_SIZE_Y))
            sy = YW'(MAX_SIZE_Y);
        else
            sy = YW'(size_y_reg);
        sz = (size_z_reg == '0) ? ZW'(1) : size_z_reg;
    end

    // input handshake and write decision
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign do_write = in_acc && (command == mf_pkg::CMD_SAMPLE) && (in_pos_reg < vol_reg);

    // result due once every neighbor has arrived
    assign need   = (VW+1)'(out_pos_reg) + (VW+1)'(lag_reg) + (VW+1)'(1);
    assign need_c = (need > (VW+1)'(vol_reg)) ? (VW+1)'(vol_reg) : need;
    assign due    = (out_pos_reg < vol_reg) && ((VW+1)'(in_pos_reg) >= need_c);

    // neighbor address relative to the center, wrapped into the window
    always_comb
    begin
        unique case (dz_reg)
            2'd0:    z_off = -$signed((AW+2)'(plane_reg));
            2'd2:    z_off = $signed((AW+2)'(plane_reg));
            default: z_off = '0;
        endcase
        unique case (dy_reg)
            2'd0:    y_off = -$signed((AW+2)'(sx));
            2'd2:    y_off = $signed((AW+2)'(sx));
            default: y_off = '0;
        endcase
        unique case (dx_reg)
            2'd0:    x_off = -$signed((AW+2)'(1));
            2'd2:    x_off = $signed((AW+2)'(1));
            default: x_off = '0;
        endcase
        nb_sum = $signed((AW+2)'(ctr_ptr_reg)) + z_off + y_off + x_off;
        priority if (nb_sum < 0)
            nb_addr = AW'(nb_sum + $signed((AW+2)'(WIN)));
        else if (nb_sum >= $signed((AW+2)'(WIN)))
            nb_addr = AW'(nb_sum - $signed((AW+2)'(WIN)));
        else
            nb_addr = AW'(nb_sum);
    end

    // drop neighbors outside the volume faces
    assign nb_valid = !((dx_reg == 2'd0) && (ox_reg == '0))
                   && !((dx_reg == 2'd2) && (ox_reg == sx - 1'b1))
                   && !((dy_reg == 2'd0) && (oy_reg == '0))
                   && !((dy_reg == 2'd2) && (oy_reg == sy - 1'b1))
                   && !((dz_reg == 2'd0) && (oz_reg == '0))
                   && !((dz_reg == 2'd2) && (oz_reg == sz - 1'b1));

    assign ram_we   = do_write;
    assign ram_addr = (state_reg == S_IDLE) ? wr_ptr_reg : nb_addr;

    mf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WIN)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample),
        .rdata (ram_rdata)
    );

    assign sort_ctl.clear  = (state_reg == S_CHECK);
    assign sort_ctl.insert = rd_valid_reg;

    mf_sorter #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sorter (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (sort_ctl),
        .din          ($signed(ram_rdata)),
        .median_twice (sort_med)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign is_last  = (out_pos_reg + 1'b1) == vol_reg;

    // derived sizes, two register stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= PW'(MAX_SIZE_X * MAX_SIZE_Y);
            vol_reg   <= VW'(MAX_SIZE_X * MAX_SIZE_Y);
            lag_reg   <= (PW+1)'(MAX_SIZE_X * MAX_SIZE_Y + MAX_SIZE_X + 1);
        end
        else
        begin
            plane_reg <= PW'(sx) * PW'(sy);
            vol_reg   <= VW'(plane_reg) * VW'(sz);
            lag_reg   <= (PW+1)'(plane_reg) + (PW+1)'(sx) + (PW+1)'(1);
        end
    end

    // sequencer, positions and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_x_reg    <= 9'd256;
            size_y_reg    <= 9'd256;
            size_z_reg    <= ZW'(1);
            in_pos_reg    <= '0;
            out_pos_reg   <= '0;
            wr_ptr_reg    <= '0;
            ctr_ptr_reg   <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oz_reg        <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            dz_reg        <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            median_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // take a register write and restart the volume
            if (cfg_we && (cfg_index == mf_pkg::REG_SIZE_X || cfg_index == mf_pkg::REG_SIZE_Y
                           || cfg_index == mf_pkg::REG_SIZE_Z))
            begin
                unique case (cfg_index)
                    mf_pkg::REG_SIZE_X: size_x_reg <= cfg_data[8:0];
                    mf_pkg::REG_SIZE_Y: size_y_reg <= cfg_data[8:0];
                    default:            size_z_reg <= cfg_data[ZW-1:0];
                endcase
                in_pos_reg  <= '0;
                out_pos_reg <= '0;
                wr_ptr_reg  <= '0;
                ctr_ptr_reg <= '0;
                ox_reg      <= '0;
                oy_reg      <= '0;
                oz_reg      <= '0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (do_write)
                        begin
                            in_pos_reg <= in_pos_reg + 1'b1;
                            wr_ptr_reg <= (wr_ptr_reg == AW'(WIN - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
                        end
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    dx_reg <= '0;
                    dy_reg <= '0;
                    dz_reg <= '0;
                    state_reg <= due ? S_GATHER : S_IDLE;
                end
                S_GATHER:
                begin
                    // issue one neighbor read per cycle
                    rd_valid_reg <= nb_valid;
                    if (dx_reg != 2'd2)
                    begin
                        dx_reg <= dx_reg + 1'b1;
                    end
                    else
                    begin
                        dx_reg <= '0;
                        if (dy_reg != 2'd2)
                        begin
                            dy_reg <= dy_reg + 1'b1;
                        end
                        else
                        begin
                            dy_reg <= '0;
                            if (dz_reg != 2'd2)
                            begin
                                dz_reg <= dz_reg + 1'b1;
                            end
                            else
                            begin
                                dz_reg    <= '0;
                                state_reg <= S_FLUSH;
                            end
                        end
                    end
                end
                S_FLUSH:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        median_reg    <= sort_med;
                        last_reg      <= is_last;
                        state_reg     <= S_IDLE;
                        if (is_last)
                        begin
                            in_pos_reg  <= '0;
                            out_pos_reg <= '0;
                            wr_ptr_reg  <= '0;
                            ctr_ptr_reg <= '0;
                            ox_reg      <= '0;
                            oy_reg      <= '0;
                            oz_reg      <= '0;
                        end
                        else
                        begin
                            out_pos_reg <= out_pos_reg + 1'b1;
                            ctr_ptr_reg <= (ctr_ptr_reg == AW'(WIN - 1)) ? '0
                                                                          : ctr_ptr_reg + 1'b1;
                            if (ox_reg == sx - 1'b1)
                            begin
                                ox_reg <= '0;
                                if (oy_reg == sy - 1'b1)
                                begin
                                    oy_reg <= '0;
                                    oz_reg <= oz_reg + 1'b1;
                                end
                                else
                                begin
                                    oy_reg <= oy_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                ox_reg <= ox_reg + 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign median_twice   = median_reg;
    assign last_of_volume = last_reg;

endmodule

`default_nettype wire

// File: sim/testbench.sv
`default_nettype none

module testbench;

    localparam int SAMPLE_W    = 16;
    localparam int MAX_X       = 256;
    localparam int MAX_Y       = 256;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 600;
    localparam int RANDOM_ITEMS = 250;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Predicts the clipped 3x3x3 neighborhood medians of a voxel stream
    class volume_median_sb;
        localparam int WIN = 2 * MAX_X * MAX_Y + 2 * MAX_X + 3;
        logic signed [SAMPLE_W-1:0] win [WIN];
        int unsigned sx_raw;
        int unsigned sy_raw;
        int unsigned sz_raw;
        longint unsigned in_pos;
        longint unsigned out_pos;
        int volumes_done;
        logic signed [SAMPLE_W:0] med_q [$];
        bit last_q [$];

        function new();
            sx_raw = 256;
            sy_raw = 256;
            sz_raw = 1;
            in_pos = 0;
            out_pos = 0;
            volumes_done = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [mf_pkg::CFG_W-1:0] val);
            case (idx)
                mf_pkg::REG_SIZE_X: sx_raw = val[8:0];
                mf_pkg::REG_SIZE_Y: sy_raw = val[8:0];
                mf_pkg::REG_SIZE_Z: sz_raw = val;
                default: return;
            endcase
            in_pos = 0;
            out_pos = 0;
        endfunction

        function longint unsigned clamp(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function longint unsigned sx();
            return clamp(sx_raw, MAX_X);
        endfunction

        function longint unsigned sy();
            return clamp(sy_raw, MAX_Y);
        endfunction

        function longint unsigned vol_size();
            return sx() * sy() * clamp(sz_raw, 65535);
        endfunction

        function bit volume_full();
            return in_pos >= vol_size();
        endfunction

        // Sort the neighborhood as it is gathered and take the middle
        function logic signed [SAMPLE_W:0] median_at(longint unsigned p);
            int vals [27];
            int n;
            int j;
            int s;
            longint x, y, z, xx, yy, zz, nx, ny, nz;
            longint unsigned q;
            nx = sx();
            ny = sy();
            nz = clamp(sz_raw, 65535);
            x = p % nx;
            y = (p / nx) % ny;
            z = p / (nx * ny);
            n = 0;
            for (int dz = -1; dz <= 1; dz++)
            begin
                for (int dy = -1; dy <= 1; dy++)
                begin
                    for (int dx = -1; dx <= 1; dx++)
                    begin
                        zz = z + dz;
                        yy = y + dy;
                        xx = x + dx;
                        if (zz < 0 || zz >= nz || yy < 0 || yy >= ny || xx < 0 || xx >= nx)
                            continue;
                        q = zz * nx * ny + yy * nx + xx;
                        s = win[q % WIN];
                        j = n;
                        while (j > 0 && vals[j-1] > s)
                        begin
                            vals[j] = vals[j-1];
                            j--;
                        end
                        vals[j] = s;
                        n++;
                    end
                end
            end
            if (n % 2)
                return (SAMPLE_W+1)'(2 * vals[n/2]);
            return (SAMPLE_W+1)'(vals[n/2 - 1] + vals[n/2]);
        endfunction

        // Take in an accepted transaction and queue any result it releases
        function void note_input(logic cmd, logic signed [SAMPLE_W-1:0] smp);
            longint unsigned need;
            longint unsigned vol;
            vol = vol_size();
            if (cmd == mf_pkg::CMD_SAMPLE && in_pos < vol)
            begin
                win[in_pos % WIN] = smp;
                in_pos++;
            end
            if (out_pos >= vol) return;
            need = out_pos + sx() * sy() + sx() + 2;
            if (need > vol) need = vol;
            if (in_pos < need) return;
            med_q.push_back(median_at(out_pos));
            out_pos++;
            if (out_pos == vol)
            begin
                last_q.push_back(1'b1);
                in_pos = 0;
                out_pos = 0;
                volumes_done++;
            end
            else
                last_q.push_back(1'b0);
        endfunction

        function int pending();
            return med_q.size();
        endfunction

        // Compare one result with the oldest expectation
        function bit check_result(logic signed [SAMPLE_W:0] med, logic lst, output string why);
            logic signed [SAMPLE_W:0] exp_med;
            bit exp_last;
            why = "";
            if (med_q.size() == 0)
            begin
                why = $sformatf("unexpected result median_twice=%0d", med);
                return 0;
            end
            exp_med = med_q.pop_front();
            exp_last = last_q.pop_front();
            if (med !== exp_med)
                why = $sformatf("median_twice %0d, want %0d", med, exp_med);
            if (lst !== exp_last)
                why = {why, $sformatf(" last_of_volume %0b, want %0b", lst, exp_last)};
            return why == "";
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic command;
    logic signed [SAMPLE_W-1:0] sample;
    logic out_valid;
    logic out_ready;
    logic signed [SAMPLE_W:0] median_twice;
    logic last_of_volume;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [mf_pkg::CFG_W-1:0] cfg_data;

    volume_median_sb medians;
    int errors;
    longint cycle_count;
    bit sender_busy;
    bit receiver_busy;
    bit hold_pending;
    bit hold_used;
    int random_items;

    median_filter_3x3x3_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .sample(sample),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .median_twice(median_twice),
        .last_of_volume(last_of_volume),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task report(input string why);
        errors++;
        $display("[%0d] mismatch: %s", cycle_count, why);
    endtask

    // Drive one input transaction, after a random gap unless the sender is busy
    task send_item(input logic cmd, input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        gap = sender_busy ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        sample <= smp;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        medians.note_input(cmd, smp);
    endtask

    function logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 4))
            0: return SAMPLE_W'(-32768);
            1: return SAMPLE_W'(32767);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Write all three sizes, optionally poking the unused index too
    task write_sizes(input int unsigned x, input int unsigned y, input int unsigned z,
                     input bit poke_unused);
        logic [1:0] idx [4];
        logic [mf_pkg::CFG_W-1:0] val [4];
        int n;
        idx[0] = mf_pkg::REG_SIZE_X; val[0] = mf_pkg::CFG_W'(x);
        idx[1] = mf_pkg::REG_SIZE_Y; val[1] = mf_pkg::CFG_W'(y);
        idx[2] = mf_pkg::REG_SIZE_Z; val[2] = mf_pkg::CFG_W'(z);
        idx[3] = REG_UNUSED; val[3] = mf_pkg::CFG_W'($urandom);
        n = poke_unused ? 4 : 3;
        for (int i = 0; i < n; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            medians.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    // Drain all expectations, then let the sequencer settle
    task wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (medians.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Feed one whole volume with drains and dropped samples mixed in
    task run_volume(input bit extremes);
        int target;
        int k;
        logic signed [SAMPLE_W-1:0] smp;
        target = medians.volumes_done + 1;
        k = 0;
        while (medians.volumes_done < target)
        begin
            smp = extremes ? ((k % 2) ? 16'sh7fff : -16'sh8000) : rand_sample();
            if (!medians.volume_full())
                send_item(($urandom_range(0, 9) == 0) ? mf_pkg::CMD_DRAIN
                                                       : mf_pkg::CMD_SAMPLE, smp);
            else
                send_item(($urandom_range(0, 3) == 0) ? mf_pkg::CMD_SAMPLE
                                                       : mf_pkg::CMD_DRAIN, smp);
            k++;
            random_items++;
        end
    endtask

    // Accept results with random stalls and one long hold-off
    initial
    begin
        int stall;
        string why;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = receiver_busy ? 0 : $urandom_range(0, 18);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (!medians.check_result(median_twice, last_of_volume, why))
                report(why);
        end
    end

    initial
    begin
        medians = new();
        errors = 0;
        random_items = 0;
        sender_busy = 0;
        receiver_busy = 0;
        hold_pending = 0;
        hold_used = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = mf_pkg::CMD_SAMPLE;
        sample = '0;
        cfg_we = 1'b0;
        cfg_index = mf_pkg::REG_SIZE_X;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: even neighborhoods at the sample extremes, drain with nothing ready
        write_sizes(2, 2, 2, 1);
        send_item(mf_pkg::CMD_DRAIN, 16'sh1234);
        run_volume(1);
        wait_idle();

        // Single voxel volume
        write_sizes(1, 1, 1, 0);
        run_volume(0);
        wait_idle();

        // Oversized x clamps to the widest row, zero sizes act as one
        write_sizes(511, 0, 0, 0);
        run_volume(0);
        wait_idle();

        // Deepest volume, left unfinished and restarted by the next write
        write_sizes(1, 1, 65535, 1);
        for (int i = 0; i < 20; i++)
            send_item(mf_pkg::CMD_SAMPLE, rand_sample());
        wait_idle();

        // Random small volumes; one phase stalls the output to back up the input
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            write_sizes($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(1, 4),
                        $urandom_range(0, 3) == 0);
            for (int v = $urandom_range(1, 3); v > 0; v--)
            begin
                sender_busy = $urandom_range(0, 3) == 0;
                receiver_busy = $urandom_range(0, 3) == 0;
                if (random_items > 80 && !hold_used)
                begin
                    sender_busy = 1;
                    hold_pending = 1;
                    hold_used = 1;
                end
                run_volume(0);
            end
            sender_busy = 0;
            receiver_busy = 0;
            wait_idle();
        end

        wait_idle();
        if (medians.pending() != 0)
            report("expectations left over");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire

// File: files.f
rtl/core/mf_pkg.sv
rtl/core/mf_ram.sv
rtl/core/mf_sorter.sv
rtl/core/median_filter_3x3x3_core.sv
sim/testbench.sv
